FILE: src/clsd_pkg.sv
// Shared types and status codes for the compacting list with search and delete.
`default_nettype none

package clsd_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // per-cell control from the list controller
    typedef struct packed {
        logic append;   // append transaction that fits
        logic remove;   // remove transaction
        logic held;     // cell index below the count
        logic tail;     // cell index equals the count
    } clsd_ctrl_t;

endpackage

`default_nettype wire

FILE: src/clsd_cell.sv
// One storage cell of the list: holds an entry, compares it, shifts down on delete.
`default_nettype none

module clsd_cell
    import clsd_pkg::*;
(
    input  wire logic                      clk,
    input  wire clsd_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] item_value,
    input  wire logic signed [VALUE_W-1:0] upper_value,  // value of the next cell up
    input  wire logic                      hit_in,       // an older held entry matched
    output logic                           hit_out,
    output logic signed [VALUE_W-1:0]      value
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      own_hit;

    assign own_hit = ctrl.held && (value_reg == item_value);
    assign hit_out = hit_in || own_hit;
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.append && ctrl.tail)
        begin
            value_next = item_value;
        end
        else if (ctrl.remove && ctrl.held && hit_out)
        begin
            // this cell is the deleted one or sits above it
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

FILE: src/compacting_list_search_delete.sv
// Top level: list controller, row of storage cells and registered result stage.
//
//   channel   signals                                            dir
//   request   in_valid, in_ready, operation, item_value          in
//   result    out_valid, out_ready, status, removed_value,       out
//             stored_count, list_empty
//
// One request per cycle while in_ready is high; its result is registered and appears in the cycle after acceptance.
// Search and compaction happen in one pass over the cell row, with the
// first-match flag rippling from cell 0 upward.
// Reset clears the count and the result valid; entries stay unknown until written.
// in_ready drops only while a result is held and out_ready is low.
`default_nettype none

module compacting_list_search_delete
    import clsd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic signed [VALUE_W-1:0] item_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [STATUS_W-1:0]            status,
    output logic signed [VALUE_W-1:0]      removed_value,
    output logic [COUNT_W-1:0]             stored_count,
    output logic                           list_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [VALUE_W-1:0] removed_reg;
    logic signed [VALUE_W-1:0] removed_next;

    logic                      accept;
    logic                      full;
    logic                      found;
    logic [DEPTH:0]            hit_chain;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            clsd_ctrl_t                ctrl;
            logic signed [VALUE_W-1:0] upper;

            assign ctrl.append = accept && (operation == OP_APPEND) && !full;
            assign ctrl.remove = accept && (operation == OP_REMOVE);
            assign ctrl.held   = (CNT_W'(gi) < count_reg);
            assign ctrl.tail   = (CNT_W'(gi) == count_reg);

            if (gi < DEPTH - 1)
            begin : g_mid
                assign upper = cell_value[gi + 1];
            end
            else
            begin : g_top
                // top cell only shifts when it is the last held one: value is dropped
                assign upper = cell_value[gi];
            end

            clsd_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .item_value  (item_value),
                .upper_value (upper),
                .hit_in      (hit_chain[gi]),
                .hit_out     (hit_chain[gi + 1]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            removed_next   = '0;
            if (operation == OP_APPEND)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                priority if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOMATCH;
                end
                else
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = item_value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // count register doubles as the post-request count once the result is shown
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign list_empty    = (count_reg == '0);

    generate
        if (CNT_W >= COUNT_W)
        begin : g_cnt_trunc
            assign stored_count = count_reg[COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign stored_count = {{(COUNT_W - CNT_W){1'b0}}, count_reg};
        end
    endgenerate

endmodule

`default_nettype wire
